// ----- rtl/core/pds_pkg.sv -----
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the polyline delta splitter.
// ----------------------------------------------------------------------------
package pds_pkg;

    // Width of a full-precision coordinate difference.
    localparam int DIFF_W = 33;
    // Largest magnitude of one emitted step.
    localparam int STEP_MAX = 32'h7fff;
    // Width of a step on one axis.
    localparam int STEP_W = 16;
    // Width of the minor-axis quotient (its magnitude never exceeds STEP_MAX).
    localparam int QUO_W = 15;
    // Default limit on midpoints for one point.
    localparam int MAX_SPLITS_DEF = 63;
    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // One classified point: the difference from the reference to the point.
    typedef struct packed {
        logic signed [DIFF_W-1:0] dlon;
        logic signed [DIFF_W-1:0] dlat;
    } t_delta;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } t_q_stat;

endpackage

// ----- rtl/core/pds_front.sv -----
// ----------------------------------------------------------------------------
// pds_front
// Accepts shape points, picks the reference and forms the 33-bit differences.
// ----------------------------------------------------------------------------
module pds_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_starts_line,
    input  logic signed [31:0]    i_line_start_lon,
    input  logic signed [31:0]    i_line_start_lat,
    input  logic signed [31:0]    i_point_lon,
    input  logic signed [31:0]    i_point_lat,
    input  pds_pkg::t_q_stat      i_q_stat,
    output logic                  o_push,
    output pds_pkg::t_delta       o_push_data
);

    // The reference after every point is that point, so the front only has
    // to remember the last accepted point.
    logic signed [31:0] r_prev_lon;
    logic signed [31:0] r_prev_lat;
    logic signed [31:0] base_lon;
    logic signed [31:0] base_lat;

    assign o_in_ready = i_q_stat.not_full;
    assign o_push     = i_in_valid && i_q_stat.not_full;

    assign base_lon = i_starts_line ? i_line_start_lon : r_prev_lon;
    assign base_lat = i_starts_line ? i_line_start_lat : r_prev_lat;

    assign o_push_data.dlon = {i_point_lon[31], i_point_lon} - {base_lon[31], base_lon};
    assign o_push_data.dlat = {i_point_lat[31], i_point_lat} - {base_lat[31], base_lat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_lon <= '0;
            r_prev_lat <= '0;
        end else if (o_push) begin
            r_prev_lon <= i_point_lon;
            r_prev_lat <= i_point_lat;
        end
    end

endmodule

// ----- rtl/core/pds_queue.sv -----
// ----------------------------------------------------------------------------
// pds_queue
// Short first-in first-out queue of differences between front and back.
// ----------------------------------------------------------------------------
module pds_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pds_pkg::t_delta   i_push_data,
    input  logic              i_pop,
    output pds_pkg::t_delta   o_head,
    output pds_pkg::t_q_stat  o_stat
);

    localparam int DEPTH = pds_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pds_pkg::t_delta  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.not_full  = (r_count != CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/pds_back.sv -----
// ----------------------------------------------------------------------------
// pds_back
// Splits each difference into midpoint steps and a final step, with a
// bit-serial divider for the minor axis and a registered result stage.
// ----------------------------------------------------------------------------
module pds_back #(
    parameter int MAX_SPLITS = pds_pkg::MAX_SPLITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pds_pkg::t_delta           i_head,
    input  pds_pkg::t_q_stat          i_q_stat,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [15:0]        o_step_lon,
    output logic signed [15:0]        o_step_lat,
    output logic                      o_is_midpoint,
    output logic                      o_last_of_run,
    output logic                      o_split_overflow
);

    localparam int DW    = pds_pkg::DIFF_W;
    localparam int SW    = pds_pkg::STEP_W;
    localparam int QW    = pds_pkg::QUO_W;
    localparam int CNT_W = $clog2(MAX_SPLITS + 1);
    localparam int BIT_W = $clog2(QW);
    localparam int NUM_W = DW + QW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_MID  = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    logic signed [DW-1:0]    r_dlon, n_dlon;
    logic signed [DW-1:0]    r_dlat, n_dlat;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_lon_major, n_lon_major;
    logic                    r_neg_major, n_neg_major;
    logic                    r_neg_minor, n_neg_minor;
    logic [DW-1:0]           r_den, n_den;
    logic [DW-1:0]           r_amin, n_amin;
    logic [DW-1:0]           r_rem, n_rem;
    logic [QW-1:0]           r_num_lo, n_num_lo;
    logic [QW-1:0]           r_quo, n_quo;
    logic [BIT_W-1:0]        r_bit, n_bit;

    logic                    r_out_valid;
    logic signed [SW-1:0]    r_step_lon, n_step_lon;
    logic signed [SW-1:0]    r_step_lat, n_step_lat;
    logic                    r_is_mid, n_is_mid;
    logic                    r_last, n_last;
    logic                    r_ovf, n_ovf;
    logic                    out_load;
    logic                    out_free;

    logic [DW-1:0]           alon;
    logic [DW-1:0]           alat;
    logic                    fits_step;
    logic                    done_split;
    logic                    lon_major;
    logic [NUM_W-1:0]        num;
    logic [DW:0]             trial;
    logic                    ge;
    logic signed [SW-1:0]    step_major;
    logic signed [SW-1:0]    step_minor;

    assign out_free = !r_out_valid || i_out_ready;

    assign alon  = r_dlon[DW-1] ? DW'(-r_dlon) : DW'(r_dlon);
    assign alat  = r_dlat[DW-1] ? DW'(-r_dlat) : DW'(r_dlat);
    // Both magnitudes fit in 15 bits: the final step needs no split.
    assign fits_step  = (alon[DW-1:QW] == '0) && (alat[DW-1:QW] == '0);
    assign done_split = (r_cnt >= CNT_W'(MAX_SPLITS));
    // Longitude wins a tie; a zero longitude difference makes latitude major.
    assign lon_major  = (r_dlon != '0) && (alat <= alon);

    // 0x7fff * |minor| as a shift and subtract.
    assign num   = {r_amin, {QW{1'b0}}} - {{QW{1'b0}}, r_amin};
    assign trial = {r_rem, r_num_lo[r_bit]};
    assign ge    = (trial >= {1'b0, r_den});

    assign step_major = r_neg_major ? -SW'(pds_pkg::STEP_MAX) : SW'(pds_pkg::STEP_MAX);
    assign step_minor = r_neg_minor ? -{1'b0, r_quo} : {1'b0, r_quo};

    always_comb begin
        n_state     = r_state;
        n_dlon      = r_dlon;
        n_dlat      = r_dlat;
        n_cnt       = r_cnt;
        n_lon_major = r_lon_major;
        n_neg_major = r_neg_major;
        n_neg_minor = r_neg_minor;
        n_den       = r_den;
        n_amin      = r_amin;
        n_rem       = r_rem;
        n_num_lo    = r_num_lo;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_step_lon  = r_step_lon;
        n_step_lat  = r_step_lat;
        n_is_mid    = r_is_mid;
        n_last      = r_last;
        n_ovf       = r_ovf;
        out_load    = 1'b0;
        o_pop       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_stat.not_empty) begin
                    o_pop   = 1'b1;
                    n_dlon  = i_head.dlon;
                    n_dlat  = i_head.dlat;
                    n_cnt   = '0;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (fits_step || done_split) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        n_step_lon = r_dlon[SW-1:0];
                        n_step_lat = r_dlat[SW-1:0];
                        n_is_mid   = 1'b0;
                        n_last     = 1'b1;
                        n_ovf      = !fits_step;
                        // Take the next point straight away when one waits.
                        if (i_q_stat.not_empty) begin
                            o_pop   = 1'b1;
                            n_dlon  = i_head.dlon;
                            n_dlat  = i_head.dlat;
                            n_cnt   = '0;
                            n_state = S_EVAL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_lon_major = lon_major;
                    if (lon_major) begin
                        n_den       = alon;
                        n_amin      = alat;
                        n_neg_major = r_dlon[DW-1];
                        n_neg_minor = r_dlat[DW-1];
                    end else begin
                        n_den       = alat;
                        n_amin      = alon;
                        n_neg_major = r_dlat[DW-1];
                        n_neg_minor = r_dlon[DW-1];
                    end
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                // The quotient is below 2^15, so the upper numerator bits
                // start as the partial remainder.
                n_rem    = num[NUM_W-1:QW];
                n_num_lo = num[QW-1:0];
                n_quo    = '0;
                n_bit    = BIT_W'(QW - 1);
                n_state  = S_DIV;
            end
            S_DIV: begin
                n_rem = ge ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                n_quo = {r_quo[QW-2:0], ge};
                if (r_bit == '0) begin
                    n_state = S_MID;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_MID: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_lon_major) begin
                        n_step_lon = step_major;
                        n_step_lat = step_minor;
                    end else begin
                        n_step_lon = step_minor;
                        n_step_lat = step_major;
                    end
                    n_is_mid = 1'b1;
                    n_last   = 1'b0;
                    n_ovf    = 1'b0;
                    n_dlon   = r_dlon - {{(DW-SW){n_step_lon[SW-1]}}, n_step_lon};
                    n_dlat   = r_dlat - {{(DW-SW){n_step_lat[SW-1]}}, n_step_lat};
                    n_cnt    = r_cnt + 1'b1;
                    n_state  = S_EVAL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dlon      <= n_dlon;
        r_dlat      <= n_dlat;
        r_lon_major <= n_lon_major;
        r_neg_major <= n_neg_major;
        r_neg_minor <= n_neg_minor;
        r_den       <= n_den;
        r_amin      <= n_amin;
        r_rem       <= n_rem;
        r_num_lo    <= n_num_lo;
        r_quo       <= n_quo;
        r_bit       <= n_bit;
        r_step_lon  <= n_step_lon;
        r_step_lat  <= n_step_lat;
        r_is_mid    <= n_is_mid;
        r_last      <= n_last;
        r_ovf       <= n_ovf;
    end

    assign o_out_valid      = r_out_valid;
    assign o_step_lon       = r_step_lon;
    assign o_step_lat       = r_step_lat;
    assign o_is_midpoint    = r_is_mid;
    assign o_last_of_run    = r_last;
    assign o_split_overflow = r_ovf;

endmodule

// ----- rtl/core/polyline_delta_splitter.sv -----
// A point that needs no midpoint passes through the queue, the back end's evaluate state
// and the result register. Such points sustain one per cycle while the output is ready;
// each midpoint passes through evaluate, prepare, the bit-serial divider and emit.
// A two-entry queue lets the input side keep taking points while a split is in progress.
// Reset (synchronous, active low) clears the reference to zero and empties the queue
// and the result register.
// ----------------------------------------------------------------------------
// polyline_delta_splitter
// Turns absolute shape points into 16-bit relative steps, inserting midpoints
// where a difference exceeds the step range, up to MAX_SPLITS of them per point.
// ----------------------------------------------------------------------------
module polyline_delta_splitter #(
    parameter int MAX_SPLITS = pds_pkg::MAX_SPLITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_starts_line,
    input  logic signed [31:0]  i_line_start_lon,
    input  logic signed [31:0]  i_line_start_lat,
    input  logic signed [31:0]  i_point_lon,
    input  logic signed [31:0]  i_point_lat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_step_lon,
    output logic signed [15:0]  o_step_lat,
    output logic                o_is_midpoint,
    output logic                o_last_of_run,
    output logic                o_split_overflow
);

    pds_pkg::t_q_stat q_stat;
    pds_pkg::t_delta  push_data;
    pds_pkg::t_delta  head;
    logic             push;
    logic             pop;

    pds_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_starts_line    (i_starts_line),
        .i_line_start_lon (i_line_start_lon),
        .i_line_start_lat (i_line_start_lat),
        .i_point_lon      (i_point_lon),
        .i_point_lat      (i_point_lat),
        .i_q_stat         (q_stat),
        .o_push           (push),
        .o_push_data      (push_data)
    );

    pds_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    pds_back #(
        .MAX_SPLITS (MAX_SPLITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_q_stat         (q_stat),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_step_lon       (o_step_lon),
        .o_step_lat       (o_step_lat),
        .o_is_midpoint    (o_is_midpoint),
        .o_last_of_run    (o_last_of_run),
        .o_split_overflow (o_split_overflow)
    );

endmodule
